FILE: hdl/bba_pkg.sv
// Shared types, codes and sizes of the bitmap block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS_DEFAULT = 4096;
    localparam int WORD_W = 64;
    localparam int BIT_IDX_W = 6;

    localparam int OPCODE_W = 1;
    localparam int BLOCK_W = 12;
    localparam int COUNT_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [CFG_DATA_W-1:0] FIRST_DATA_BLOCK_RESET = 13'd17;
    localparam logic [CFG_DATA_W-1:0] BLOCK_LIMIT_RESET = 13'd4096;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DATA_BLOCK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_NOSPACE = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

FILE: hdl/bba_if.sv
// Channel interfaces of the allocator: request, response and configuration write.
interface bba_req_if;
    logic                              valid;
    logic                              ready;
    logic [bba_pkg::OPCODE_W-1:0]      opcode;
    logic [bba_pkg::BLOCK_W-1:0]       block_number;

    modport source (output valid, output opcode, output block_number, input ready);
    modport sink (input valid, input opcode, input block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                              valid;
    logic                              ready;
    bba_pkg::status_t                  status;
    logic [bba_pkg::BLOCK_W-1:0]       granted_block;
    logic [bba_pkg::COUNT_W-1:0]       used_count;

    modport source (output valid, output status, output granted_block, output used_count,
                    input ready);
    modport sink (input valid, input status, input granted_block, input used_count,
                  output ready);
endinterface

interface bba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bba_pkg::CFG_INDEX_W-1:0]   index;
    logic [bba_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/bitmap_block_allocator.sv
// Top level of the bitmap first-fit block allocator.
//
// Channel  Role   Beat contents
// req      sink   opcode, block_number
// rsp      source status, granted_block, used_count
// cfg      sink   index, data (always ready)
//
// An allocate scans map words, from the one holding the first data block up to
// the one holding the last block below the limit, in ST_SCAN, then goes to ST_RESP.
// A free reads its map word in ST_FREE; a rejected request goes straight to ST_RESP.
// After reset the map is cleared one word per cycle in ST_CLEAR,
// with req held not ready. A stalled rsp holds the next result in place.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    bba_req_if.sink     req,
    bba_rsp_if.source   rsp,
    bba_cfg_if.sink     cfg
);

    localparam int MapWords = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
    localparam int AddrW = (MapWords > 1) ? $clog2(MapWords) : 1;
    localparam int CntW = $clog2(NUM_BLOCKS + 1);
    localparam int LimW = (CntW > bba_pkg::COUNT_W) ? CntW : bba_pkg::COUNT_W;
    localparam int WordW = bba_pkg::WORD_W;
    localparam int BitW = bba_pkg::BIT_IDX_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FREE  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [bba_pkg::CFG_DATA_W-1:0] first_reg, limit_reg;
    logic [AddrW-1:0]              clr_addr_reg, clr_addr_next;
    logic [CntW-1:0]               used_reg, used_next;
    logic [AddrW-1:0]              word_reg, word_next;
    logic [AddrW-1:0]              first_word_reg, first_word_next;
    logic [AddrW-1:0]              last_word_reg, last_word_next;
    logic [WordW-1:0]              lo_mask_reg, lo_mask_next;
    logic [WordW-1:0]              hi_mask_reg, hi_mask_next;
    logic [BitW-1:0]               bit_reg, bit_next;
    logic                          pend_we_reg, pend_we_next;
    logic [WordW-1:0]              pend_wdata_reg, pend_wdata_next;
    bba_pkg::status_t              pend_status_reg, pend_status_next;
    logic [bba_pkg::BLOCK_W-1:0]   pend_granted_reg, pend_granted_next;
    logic [CntW-1:0]               pend_count_reg, pend_count_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    bba_pkg::status_t              rsp_status_reg, rsp_status_next;
    logic [bba_pkg::BLOCK_W-1:0]   rsp_granted_reg, rsp_granted_next;
    logic [bba_pkg::COUNT_W-1:0]   rsp_count_reg, rsp_count_next;

    logic                          mem_we;
    logic [AddrW-1:0]              mem_waddr, mem_raddr;
    logic [WordW-1:0]              mem_wdata, mem_rdata;

    logic [LimW-1:0]               first_ext, limit_ext, eff_limit, last_block, blk_ext;
    logic [LimW-1:0]               count_ext;
    logic                          req_fire, rsp_slot_free;
    logic [WordW-1:0]              word_mask, avail, lowest;
    logic [BitW-1:0]               lowest_idx;

    bba_ram #(
        .WIDTH (WordW),
        .DEPTH (MapWords)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire = req.valid && req.ready;
    assign rsp_slot_free = !rsp_valid_reg || rsp.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.granted_block = rsp_granted_reg;
    assign rsp.used_count = rsp_count_reg;

    assign first_ext = LimW'(first_reg);
    assign limit_ext = LimW'(limit_reg);
    assign eff_limit = (limit_ext > LimW'(NUM_BLOCKS)) ? LimW'(NUM_BLOCKS) : limit_ext;
    assign last_block = eff_limit - LimW'(1);
    assign blk_ext = LimW'(req.block_number);

    always_comb
    begin
        word_mask = '1;
        if (word_reg == first_word_reg)
        begin
            word_mask = word_mask & lo_mask_reg;
        end
        if (word_reg == last_word_reg)
        begin
            word_mask = word_mask & hi_mask_reg;
        end
    end

    assign avail = ~mem_rdata & word_mask;
    assign lowest = avail & (~avail + WordW'(1));

    always_comb
    begin
        lowest_idx = '0;
        for (int j = 0; j < WordW; j++)
        begin
            if (lowest[j])
            begin
                lowest_idx = lowest_idx | BitW'(j);
            end
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = word_reg;
        mem_wdata = pend_wdata_reg;
        mem_raddr = word_reg + AddrW'(1);
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_RESP)
        begin
            mem_we = pend_we_reg && rsp_slot_free;
        end
        if (state_reg == ST_IDLE)
        begin
            mem_raddr = (req.opcode == bba_pkg::OP_FREE) ? blk_ext[BitW +: AddrW]
                                                         : first_ext[BitW +: AddrW];
        end
    end

    assign count_ext = LimW'(pend_count_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_addr_next = clr_addr_reg;
        used_next = used_reg;
        word_next = word_reg;
        first_word_next = first_word_reg;
        last_word_next = last_word_reg;
        lo_mask_next = lo_mask_reg;
        hi_mask_next = hi_mask_reg;
        bit_next = bit_reg;
        pend_we_next = pend_we_reg;
        pend_wdata_next = pend_wdata_reg;
        pend_status_next = pend_status_reg;
        pend_granted_next = pend_granted_reg;
        pend_count_next = pend_count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_granted_next = rsp_granted_reg;
        rsp_count_next = rsp_count_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AddrW'(1);
                if (clr_addr_reg == AddrW'(MapWords - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    pend_we_next = 1'b0;
                    pend_granted_next = '0;
                    pend_count_next = used_reg;
                    pend_status_next = bba_pkg::STATUS_DONE;
                    if (req.opcode == bba_pkg::OP_ALLOC)
                    begin
                        word_next = first_ext[BitW +: AddrW];
                        first_word_next = first_ext[BitW +: AddrW];
                        last_word_next = last_block[BitW +: AddrW];
                        lo_mask_next = {WordW{1'b1}} << first_ext[BitW-1:0];
                        hi_mask_next = {WordW{1'b1}} >> (BitW'(WordW - 1) - last_block[BitW-1:0]);
                        if (first_ext >= eff_limit)
                        begin
                            pend_status_next = bba_pkg::STATUS_NOSPACE;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        word_next = blk_ext[BitW +: AddrW];
                        bit_next = blk_ext[BitW-1:0];
                        if (blk_ext < first_ext || blk_ext >= eff_limit)
                        begin
                            pend_status_next = bba_pkg::STATUS_RANGE;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_FREE;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (avail != '0)
                begin
                    pend_we_next = 1'b1;
                    pend_wdata_next = mem_rdata | lowest;
                    pend_granted_next = bba_pkg::BLOCK_W'({word_reg, lowest_idx});
                    pend_count_next = used_reg + CntW'(1);
                    state_next = ST_RESP;
                end
                else if (word_reg == last_word_reg)
                begin
                    pend_status_next = bba_pkg::STATUS_NOSPACE;
                    state_next = ST_RESP;
                end
                else
                begin
                    word_next = word_reg + AddrW'(1);
                end
            end
            ST_FREE:
            begin
                if (mem_rdata[bit_reg])
                begin
                    pend_we_next = 1'b1;
                    pend_wdata_next = mem_rdata & ~(WordW'(1) << bit_reg);
                    pend_count_next = used_reg - CntW'(1);
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_slot_free)
                begin
                    used_next = pend_count_reg;
                    rsp_valid_next = 1'b1;
                    rsp_status_next = pend_status_reg;
                    rsp_granted_next = pend_granted_reg;
                    rsp_count_next = (count_ext > LimW'(bba_pkg::COUNT_MAX)) ? bba_pkg::COUNT_MAX
                                                     : count_ext[bba_pkg::COUNT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_addr_reg <= '0;
            used_reg <= '0;
            rsp_valid_reg <= 1'b0;
            first_reg <= bba_pkg::FIRST_DATA_BLOCK_RESET;
            limit_reg <= bba_pkg::BLOCK_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_addr_reg <= clr_addr_next;
            used_reg <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    bba_pkg::REG_FIRST_DATA_BLOCK: first_reg <= cfg.data;
                    bba_pkg::REG_BLOCK_LIMIT:      limit_reg <= cfg.data;
                    default:                       first_reg <= first_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        first_word_reg <= first_word_next;
        last_word_reg <= last_word_next;
        lo_mask_reg <= lo_mask_next;
        hi_mask_reg <= hi_mask_next;
        bit_reg <= bit_next;
        pend_we_reg <= pend_we_next;
        pend_wdata_reg <= pend_wdata_next;
        pend_status_reg <= pend_status_next;
        pend_granted_reg <= pend_granted_next;
        pend_count_reg <= pend_count_next;
        rsp_status_reg <= rsp_status_next;
        rsp_granted_reg <= rsp_granted_next;
        rsp_count_reg <= rsp_count_next;
    end

`ifndef ASSERT_OFF
    a_write_only_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_RESP))
        else $error("Map written outside the clear pass or response cycle.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        LimW'(used_reg) <= LimW'(NUM_BLOCKS))
        else $error("Used block count exceeds the map size.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (word_reg >= first_word_reg && word_reg <= last_word_reg))
        else $error("Scan left the data range.");

    a_nospace_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg != bba_pkg::STATUS_DONE |-> rsp_granted_reg == '0)
        else $error("Block granted on a failed request.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESP && rsp_slot_free && !pend_we_reg |=> $stable(used_reg))
        else $error("Count changed without a map update.");
`endif

endmodule
